// ===== src/srx_pkg.sv =====
// Package for the serial byte receiver: phase encoding, register indexes,
// reset values and shared field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srx_pkg;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_SAMPLE    = 2'd1,
        PH_WAIT_HIGH = 2'd2,
        PH_GUARD     = 2'd3
    } phase_t;

    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t REG_START_OFFSET = 3'd0;
    localparam cfg_idx_t REG_BIT_PERIOD   = 3'd1;
    localparam cfg_idx_t REG_STOP_GUARD   = 3'd2;
    localparam cfg_idx_t REG_FRAME_LENGTH = 3'd3;

    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] START_OFFSET_RST = 16'd40;
    localparam logic [15:0] BIT_PERIOD_RST   = 16'd100;
    localparam logic [15:0] STOP_GUARD_RST   = 16'd100;
    localparam logic [7:0]  FRAME_LENGTH_RST = 8'd4;

    localparam logic [3:0] DATA_BITS      = 4'd8;
    localparam logic [7:0] FIRST_BIT_MASK = 8'h80;

endpackage

`default_nettype wire

// ===== src/srx_in_if.sv =====
// Input channel of the serial byte receiver: one line sample per request.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface srx_in_if;
    logic valid;
    logic ready;
    logic line_level;

    modport source (output valid, output line_level, input ready);
    modport sink (input valid, input line_level, output ready);
endinterface

`default_nettype wire

// ===== src/srx_out_if.sv =====
// Result channel of the serial byte receiver: one received byte per request.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface srx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       parity_fail;
    logic [7:0] byte_position;
    logic       frame_done;

    modport source (output valid, output rx_byte, output parity_fail,
                    output byte_position, output frame_done, input ready);
    modport sink (input valid, input rx_byte, input parity_fail,
                  input byte_position, input frame_done, output ready);
endinterface

`default_nettype wire

// ===== src/serial_rx_even_parity_frames.sv =====
// A line sample accepted into the sample stage loads its result (if any) into the result
// register as it leaves that stage. Throughput: one sample per cycle while results drain.
// One sample stage and one result register; a full result register that is
// not taken holds a full sample stage, which then drops ready.
// Reset (rst_n low, asynchronous): phase idle, counters and frame index zero,
// registers back to their defaults, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module serial_rx_even_parity_frames (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cfg_we,
    input  wire srx_pkg::cfg_idx_t     cfg_index,
    input  wire [srx_pkg::CFG_DATA_W-1:0] cfg_data,
    srx_in_if.sink                     rx_in,
    srx_out_if.source                  rx_out
);

    // configuration registers
    logic [15:0] start_offset_reg;
    logic [15:0] bit_period_reg;
    logic [15:0] stop_guard_reg;
    logic [7:0]  frame_length_reg;

    // sample stage
    logic s1_valid_reg;
    logic s1_line_reg;

    // receiver state
    srx_pkg::phase_t phase_reg, phase_next;
    logic [15:0] tick_timer_reg, tick_timer_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [3:0]  bits_taken_reg, bits_taken_next;
    logic [7:0]  frame_index_reg, frame_index_next;

    // result register
    logic       out_valid_reg;
    logic [7:0] rx_byte_reg;
    logic       parity_fail_reg;
    logic [7:0] byte_position_reg;
    logic       frame_done_reg;

    logic       advance;
    logic       step;
    logic       timer_gt1;
    logic       guard_over;
    logic       sample_due;
    logic       emit;
    logic       emit_fail;
    logic       emit_done;
    logic [8:0] index_plus1;

    assign advance   = !out_valid_reg || rx_out.ready;
    assign step      = s1_valid_reg && advance;
    assign rx_in.ready = !s1_valid_reg || advance;

    assign timer_gt1  = tick_timer_reg > 16'd1;
    assign guard_over = (phase_reg == srx_pkg::PH_GUARD) && !timer_gt1;
    assign sample_due = (phase_reg == srx_pkg::PH_SAMPLE) && !timer_gt1;
    assign emit       = sample_due && bits_taken_reg[3];
    assign emit_fail  = s1_line_reg != (^shift_byte_reg);
    assign index_plus1 = {1'b0, frame_index_reg} + 9'd1;
    assign emit_done  = !emit_fail && (index_plus1 >= {1'b0, frame_length_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_offset_reg <= srx_pkg::START_OFFSET_RST;
            bit_period_reg   <= srx_pkg::BIT_PERIOD_RST;
            stop_guard_reg   <= srx_pkg::STOP_GUARD_RST;
            frame_length_reg <= srx_pkg::FRAME_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                srx_pkg::REG_START_OFFSET: start_offset_reg <= cfg_data;
                srx_pkg::REG_BIT_PERIOD:   bit_period_reg   <= cfg_data;
                srx_pkg::REG_STOP_GUARD:   stop_guard_reg   <= cfg_data;
                srx_pkg::REG_FRAME_LENGTH: frame_length_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            srx_pkg::PH_GUARD:
            begin
                if (!timer_gt1)
                    phase_next = s1_line_reg ? srx_pkg::PH_IDLE : srx_pkg::PH_SAMPLE;
            end
            srx_pkg::PH_IDLE:
            begin
                if (!s1_line_reg)
                    phase_next = srx_pkg::PH_SAMPLE;
            end
            srx_pkg::PH_SAMPLE:
            begin
                if (emit)
                    phase_next = srx_pkg::PH_WAIT_HIGH;
            end
            srx_pkg::PH_WAIT_HIGH:
            begin
                if (s1_line_reg)
                    phase_next = (stop_guard_reg == 16'd0) ? srx_pkg::PH_IDLE
                                                           : srx_pkg::PH_GUARD;
            end
            default: phase_next = srx_pkg::PH_IDLE;
        endcase
    end

    // counters, shift register and frame index
    always_comb
    begin
        tick_timer_next  = tick_timer_reg;
        shift_byte_next  = shift_byte_reg;
        bits_taken_next  = bits_taken_reg;
        frame_index_next = frame_index_reg;
        priority if ((phase_reg == srx_pkg::PH_GUARD || phase_reg == srx_pkg::PH_SAMPLE)
                     && timer_gt1)
        begin
            tick_timer_next = tick_timer_reg - 16'd1;
        end
        else if ((phase_reg == srx_pkg::PH_IDLE || guard_over) && !s1_line_reg)
        begin
            // start edge
            tick_timer_next = start_offset_reg;
            shift_byte_next = 8'd0;
            bits_taken_next = 4'd0;
        end
        else if (sample_due)
        begin
            tick_timer_next = bit_period_reg;
            if (!bits_taken_reg[3])
            begin
                if (s1_line_reg)
                    shift_byte_next = shift_byte_reg
                                    | (srx_pkg::FIRST_BIT_MASK >> bits_taken_reg[2:0]);
                bits_taken_next = bits_taken_reg + 4'd1;
            end
            else
            begin
                bits_taken_next = 4'd0;
                if (emit_fail || emit_done)
                    frame_index_next = 8'd0;
                else
                    frame_index_next = index_plus1[7:0];
            end
        end
        else if (phase_reg == srx_pkg::PH_WAIT_HIGH && s1_line_reg)
        begin
            tick_timer_next = stop_guard_reg;
        end
        else
        begin
            tick_timer_next = tick_timer_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            phase_reg       <= srx_pkg::PH_IDLE;
            tick_timer_reg  <= 16'd0;
            shift_byte_reg  <= 8'd0;
            bits_taken_reg  <= 4'd0;
            frame_index_reg <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (rx_in.ready)
                s1_valid_reg <= rx_in.valid;
            if (step)
            begin
                phase_reg       <= phase_next;
                tick_timer_reg  <= tick_timer_next;
                shift_byte_reg  <= shift_byte_next;
                bits_taken_reg  <= bits_taken_next;
                frame_index_reg <= frame_index_next;
            end
            if (advance)
                out_valid_reg <= step && emit;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rx_in.ready && rx_in.valid)
            s1_line_reg <= rx_in.line_level;
        if (step && emit)
        begin
            rx_byte_reg       <= shift_byte_reg;
            parity_fail_reg   <= emit_fail;
            byte_position_reg <= frame_index_reg;
            frame_done_reg    <= emit_done;
        end
    end

    assign rx_out.valid         = out_valid_reg;
    assign rx_out.rx_byte       = rx_byte_reg;
    assign rx_out.parity_fail   = parity_fail_reg;
    assign rx_out.byte_position = byte_position_reg;
    assign rx_out.frame_done    = frame_done_reg;

endmodule

`default_nettype wire

// ===== src/srx_checker.sv =====
// Port-level checks for the serial byte receiver, attached by bind.
// Depends on serial_rx_even_parity_frames and its channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module srx_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       in_valid,
    input wire       in_ready,
    input wire       out_valid,
    input wire       out_ready,
    input wire [7:0] rx_byte,
    input wire       parity_fail,
    input wire [7:0] byte_position,
    input wire       frame_done
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rx_byte)
            && $stable(parity_fail) && $stable(byte_position) && $stable(frame_done))
        else $error("stalled result changed");

    // an empty result register never holds back a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // a fresh result comes from a request taken in through the sample stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching request");

    // an aborted byte never completes a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parity_fail |-> !frame_done)
        else $error("parity failure marked frame done");

    // frame length tops out at 255, so the position stops at 254
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_position != 8'hFF)
        else $error("byte position out of range");

endmodule

bind serial_rx_even_parity_frames srx_checker u_srx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (rx_in.valid),
    .in_ready      (rx_in.ready),
    .out_valid     (rx_out.valid),
    .out_ready     (rx_out.ready),
    .rx_byte       (rx_out.rx_byte),
    .parity_fail   (rx_out.parity_fail),
    .byte_position (rx_out.byte_position),
    .frame_done    (rx_out.frame_done)
);

`default_nettype wire
